/* src/cdq_pkg.sv */
package cdq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 32;

    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic fetch_load;
    } cdq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic fetch_needed;
    } cdq_stat_t;

endpackage

/* src/cdq_datapath.sv */
module cdq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::cdq_ctrl_t                ctrl,
    output cdq_pkg::cdq_stat_t                stat,
    input  logic [cdq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [cdq_pkg::OUT_W-1:0]  push_value,
    output logic signed [cdq_pkg::OUT_W-1:0]  popped_value,
    output logic                              pop_valid,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic signed [cdq_pkg::OUT_W-1:0]  front_value,
    output logic signed [cdq_pkg::OUT_W-1:0]  rear_value,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] rear_reg, rear_next;
    logic [OUT_W-1:0]      popped_reg, popped_next;
    logic                  pop_valid_reg, pop_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  fetch_front_reg, fetch_front_next;

    logic                  push_cmd, pop_cmd, push_ok, pop_ok;
    logic                  occ_zero, occ_full;
    logic [63:0]           push_wide;
    logic [DATA_WIDTH-1:0] push_data;
    logic                  wr_en, rd_en;
    logic [PTR_W-1:0]      wr_addr, rd_addr;

    function automatic logic [OUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
        logic signed [63:0] ext;
        ext = 64'($signed(v));
        return ext[OUT_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    assign push_wide = {32'b0, push_value};
    assign push_data = push_wide[DATA_WIDTH-1:0];

    assign occ_zero = (occ_reg == '0);
    assign occ_full = (occ_reg == OCC_FULL);
    assign push_cmd = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
    assign pop_cmd  = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_REAR);
    assign push_ok  = push_cmd && !occ_full;
    assign pop_ok   = pop_cmd && !occ_zero;

    // a pop that leaves elements behind must refetch the new end element
    assign stat.fetch_needed = pop_ok && (occ_reg != OCC_W'(1));

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        popped_next      = popped_reg;
        pop_valid_next   = pop_valid_reg;
        status_next      = status_reg;
        fetch_front_next = fetch_front_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;

        if (ctrl.exec)
        begin
            popped_next    = '0;
            pop_valid_next = 1'b0;
            status_next    = STATUS_OK;
            if (push_cmd && occ_full)
            begin
                status_next = STATUS_FULL;
            end
            else if (pop_cmd && occ_zero)
            begin
                status_next = STATUS_EMPTY;
            end

            if (push_ok)
            begin
                wr_en    = 1'b1;
                occ_next = occ_reg + 1'b1;
                if (occ_zero)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    wr_addr    = '0;
                    front_next = push_data;
                    rear_next  = push_data;
                end
                else if (cmd == CMD_PUSH_FRONT)
                begin
                    head_next  = ptr_dec(head_reg);
                    wr_addr    = head_next;
                    front_next = push_data;
                end
                else
                begin
                    tail_next = ptr_inc(tail_reg);
                    wr_addr   = tail_next;
                    rear_next = push_data;
                end
            end

            if (pop_ok)
            begin
                pop_valid_next   = 1'b1;
                occ_next         = occ_reg - 1'b1;
                fetch_front_next = (cmd == CMD_POP_FRONT);
                popped_next      = (cmd == CMD_POP_FRONT) ? to_out(front_reg)
                                                          : to_out(rear_reg);
                if (occ_reg == OCC_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cmd == CMD_POP_FRONT)
                begin
                    head_next = ptr_inc(head_reg);
                    rd_en     = 1'b1;
                    rd_addr   = head_next;
                end
                else
                begin
                    tail_next = ptr_dec(tail_reg);
                    rd_en     = 1'b1;
                    rd_addr   = tail_next;
                end
            end
        end

        if (ctrl.fetch_load)
        begin
            if (fetch_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                rear_next = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            occ_reg         <= '0;
            pop_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            fetch_front_reg <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            occ_reg         <= occ_next;
            pop_valid_reg   <= pop_valid_next;
            status_reg      <= status_next;
            fetch_front_reg <= fetch_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        rear_reg   <= rear_next;
        popped_reg <= popped_next;
    end

    assign popped_value = popped_reg;
    assign pop_valid    = pop_valid_reg;
    assign status       = status_reg;
    assign is_empty     = occ_zero;
    assign is_full      = occ_full;
    assign front_value  = occ_zero ? '1 : to_out(front_reg);
    assign rear_value   = occ_zero ? '1 : to_out(rear_reg);

endmodule

/* src/cdq_ctrl.sv */
module cdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_ctrl_t ctrl
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    assign ctrl.exec       = in_valid && in_ready_reg;
    assign ctrl.fetch_load = (state_reg == S_FETCH);
    assign in_ready        = in_ready_reg;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_ready_reg <= 1'b0;
                        if (stat.fetch_needed)
                        begin
                            state_reg <= S_FETCH;
                        end
                        else
                        begin
                            state_reg     <= S_RESULT;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg     <= S_RESULT;
                    out_valid_reg <= 1'b1;
                end
                S_RESULT:
                begin
                    // hold the result until the sink takes it
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                    in_ready_reg  <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* src/circular_deque.sv */
// Double-ended queue of DEPTH words in a circular buffer. Each request pushes
// push_value at the front or rear, pops from the front or rear, or does
// nothing, and yields exactly one result with the popped value, a status
// (full on a refused push, empty on a refused pop), the front and rear
// elements after the step (-1 when empty) and the empty and full flags.
// One request is handled at a time. A push, a no-op, a refused request or a
// pop of the last element goes from acceptance straight to the result state;
// a pop that leaves elements behind first passes through a fetch state, in
// which the new end element, read from memory into a register, is loaded
// into the front or rear register. The front and rear elements are cached in
// registers. No clearing pass follows reset.
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cdq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [cdq_pkg::OUT_W-1:0]  push_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cdq_pkg::OUT_W-1:0]  popped_value,
    output logic                              pop_valid,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic signed [cdq_pkg::OUT_W-1:0]  front_value,
    output logic signed [cdq_pkg::OUT_W-1:0]  rear_value,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    cdq_ctrl_t ctrl;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .push_value   (push_value),
        .popped_value (popped_value),
        .pop_valid    (pop_valid),
        .status       (status),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule
